// ===== rtl/pip_pkg.sv =====
// Shared constants, register codes and control structs for the point-in-polygon block.
// No dependencies; every file of the block but pip_out_if refers to this package by scoped names.
package pip_pkg;

  // Default sizing handed to the top level
  localparam int MAX_EDGES_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int EDGE_IDX_W = 6;
  localparam int EDGE_CNT_W = 7;
  localparam int RADIUS_W   = 33;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 33;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = {RADIUS_W{1'b1}};

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_EDGE_COUNT = 2'd0,
    REG_CENTER_X   = 2'd1,
    REG_CENTER_Y   = 2'd2,
    REG_RADIUS_SQ  = 2'd3
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_edge;   // write the accepted edge into the table
    logic load_pt;   // capture the query point
    logic walk_clr;  // clear edge counter and winding sum
    logic issue;     // read the next edge
    logic out_load;  // load the result register
  } pip_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bound_ok;    // point lies inside the bounding circle
    logic n_zero;      // no edges in use
    logic last_issue;  // current read is the last edge
    logic pipe_busy;   // edges still in flight
    logic out_free;    // result register can take a new value
  } pip_sts_t;

endpackage

// ===== rtl/pip_in_if.sv =====
// Input request channel: valid/ready handshake with the load or query payload.
// Depends on pip_pkg for the fixed field widths.
interface pip_in_if #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [pip_pkg::EDGE_IDX_W-1:0]  edge_index;
  logic signed [COORD_BITS-1:0]    x;
  logic signed [COORD_BITS-1:0]    y;
  logic signed [COORD_BITS-1:0]    dx;
  logic signed [COORD_BITS-1:0]    dy;

  modport source (output valid, req_type, edge_index, x, y, dx, dy, input ready);
  modport sink   (input valid, req_type, edge_index, x, y, dx, dy, output ready);
endinterface

// ===== rtl/pip_out_if.sv =====
// Result channel: valid/ready handshake carrying the inside flag.
// No dependencies.
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// ===== rtl/pip_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and write data.
// Depends on pip_pkg for index and data widths.
interface pip_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pip_pkg::CFG_IW-1:0]  index;
  logic [pip_pkg::CFG_DW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pip_ctrl.sv =====
// Controller state machine: sequences edge loads, the bound check, the edge walk
// and result delivery. Depends on pip_pkg for the command and status structs.
module pip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  output pip_pkg::pip_cmd_t cmd,
  input  pip_pkg::pip_sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQ    = 6'b000010,
    ST_CMP   = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.wr_edge = accept & (in_req_type == pip_pkg::REQ_LOAD);
        cmd.load_pt = accept & (in_req_type == pip_pkg::REQ_QUERY);
        if (accept && (in_req_type == pip_pkg::REQ_QUERY)) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        // squares settle this cycle; reset the walk meanwhile
        cmd.walk_clr = 1'b1;
        state_nxt    = ST_CMP;
      end
      ST_CMP: begin
        if (!sts.bound_ok || sts.n_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pip_dp.sv =====
// Datapath: configuration registers, edge table memory, bound check, the
// pipelined per-edge crossing test, winding sum and result register.
// Depends on pip_pkg for widths, register codes and the control structs.
module pip_dp #(
  parameter int MAX_EDGES  = pip_pkg::MAX_EDGES_DEF,
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pip_pkg::pip_cmd_t                 cmd,
  output pip_pkg::pip_sts_t                 sts,
  // request payload
  input  logic [pip_pkg::EDGE_IDX_W-1:0]    in_edge_index,
  input  logic signed [COORD_BITS-1:0]      in_x,
  input  logic signed [COORD_BITS-1:0]      in_y,
  input  logic signed [COORD_BITS-1:0]      in_dx,
  input  logic signed [COORD_BITS-1:0]      in_dy,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [pip_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [pip_pkg::CFG_DW-1:0]        cfg_data,
  // result
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_inside_res
);

  localparam int C    = COORD_BITS;
  localparam int AW   = $clog2(MAX_EDGES);
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int NW   = (CW > pip_pkg::EDGE_CNT_W) ? CW : pip_pkg::EDGE_CNT_W;
  localparam int IXW  = (CW > pip_pkg::EDGE_IDX_W) ? CW : pip_pkg::EDGE_IDX_W;
  localparam int SQW  = 2 * C + 2;
  localparam int CMPW = (SQW + 1 > pip_pkg::RADIUS_W) ? SQW + 1 : pip_pkg::RADIUS_W;
  localparam int WW   = AW + 3;
  localparam int EW   = 4 * C;

  // ---------------- configuration registers ----------------
  logic [pip_pkg::EDGE_CNT_W-1:0] edge_count_r;
  logic signed [C-1:0]            center_x_r;
  logic signed [C-1:0]            center_y_r;
  logic [pip_pkg::RADIUS_W-1:0]   radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      center_x_r   <= '0;
      center_y_r   <= '0;
      radius_r     <= pip_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      case (pip_pkg::cfg_reg_t'(cfg_index))
        pip_pkg::REG_EDGE_COUNT: edge_count_r <= cfg_data[pip_pkg::EDGE_CNT_W-1:0];
        pip_pkg::REG_CENTER_X:   center_x_r   <= cfg_data[C-1:0];
        pip_pkg::REG_CENTER_Y:   center_y_r   <= cfg_data[C-1:0];
        pip_pkg::REG_RADIUS_SQ:  radius_r     <= cfg_data[pip_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Edges in use, limited to the table size
  logic [NW-1:0] n_lim;
  always_comb begin
    if (NW'(edge_count_r) > NW'(MAX_EDGES)) begin
      n_lim = NW'(MAX_EDGES);
    end else begin
      n_lim = NW'(edge_count_r);
    end
  end

  // ---------------- edge table ----------------
  logic [EW-1:0]  edge_mem [MAX_EDGES];
  logic [IXW-1:0] wr_idx;
  logic           wr_ok;
  logic [EW-1:0]  rd_data_r;
  logic [NW-1:0]  cnt_r;

  assign wr_idx = IXW'(in_edge_index);
  assign wr_ok  = wr_idx < IXW'(MAX_EDGES);

  always_ff @(posedge clk) begin
    if (cmd.wr_edge && wr_ok) begin
      edge_mem[wr_idx[AW-1:0]] <= {in_x, in_y, in_dx, in_dy};
    end
    if (cmd.issue) begin
      rd_data_r <= edge_mem[cnt_r[AW-1:0]];
    end
  end

  // ---------------- query point and bound check ----------------
  logic signed [C-1:0] px_r, py_r;
  logic signed [C:0]   dcx, dcy;
  logic signed [SQW-1:0] sqx_prod, sqy_prod;
  logic [SQW-1:0]      sqx_r, sqy_r;
  logic [CMPW-1:0]     dist_sq;

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px_r <= in_x;
      py_r <= in_y;
    end
  end

  assign dcx      = $signed({px_r[C-1], px_r}) - $signed({center_x_r[C-1], center_x_r});
  assign dcy      = $signed({py_r[C-1], py_r}) - $signed({center_y_r[C-1], center_y_r});
  assign sqx_prod = SQW'(dcx) * SQW'(dcx);
  assign sqy_prod = SQW'(dcy) * SQW'(dcy);

  // squares registered, summed and compared next cycle
  always_ff @(posedge clk) begin
    sqx_r <= sqx_prod;
    sqy_r <= sqy_prod;
  end

  assign dist_sq = CMPW'(sqx_r) + CMPW'(sqy_r);

  // ---------------- edge counter ----------------
  always_ff @(posedge clk) begin
    if (cmd.walk_clr) begin
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + NW'(1);
    end
  end

  // ---------------- crossing pipeline ----------------
  logic v_rd_r, v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      v_rd_r <= cmd.issue;
      v1_r   <= v_rd_r;
      v2_r   <= v1_r;
    end
  end

  // Stage 1: offsets from the query point
  logic signed [C-1:0] e_sx, e_sy, e_vx, e_vy;
  logic signed [C:0]   ax_r, a_r;
  logic signed [C+1:0] b_r;
  logic signed [C-1:0] vx_r, vy_r;

  assign {e_sx, e_sy, e_vx, e_vy} = rd_data_r;

  always_ff @(posedge clk) begin
    ax_r <= $signed({e_sx[C-1], e_sx}) - $signed({px_r[C-1], px_r});
    a_r  <= $signed({e_sy[C-1], e_sy}) - $signed({py_r[C-1], py_r});
    b_r  <= $signed({e_sy[C-1], e_sy[C-1], e_sy}) - $signed({py_r[C-1], py_r[C-1], py_r})
            + $signed({e_vy[C-1], e_vy[C-1], e_vy});
    vx_r <= e_vx;
    vy_r <= e_vy;
  end

  // Stage 2: cross-product terms and sign classification
  logic signed [2*C:0] p1_r, p2_r;
  logic signed [C+1:0] axv;
  logic a_pos_r, a_neg_r, b_pos_r, b_neg_r, ax_neg_r, axv_neg_r;

  assign axv = $signed({ax_r[C], ax_r}) + $signed({vx_r[C-1], vx_r[C-1], vx_r});

  always_ff @(posedge clk) begin
    p1_r      <= (2*C+1)'(ax_r) * (2*C+1)'(vy_r);
    p2_r      <= (2*C+1)'(a_r) * (2*C+1)'(vx_r);
    a_pos_r   <= (a_r > 0);
    a_neg_r   <= a_r[C];
    b_pos_r   <= (b_r > 0);
    b_neg_r   <= b_r[C+1];
    ax_neg_r  <= ax_r[C];
    axv_neg_r <= axv[C+1];
  end

  // Stage 3: side of the crossing and contribution to the winding sum
  logic signed [2*C+1:0] xprod;
  logic                  c_pos, c_neg, left;
  logic signed [2:0]     contrib;
  logic signed [WW-1:0]  w_r;

  assign xprod = $signed({p1_r[2*C], p1_r}) - $signed({p2_r[2*C], p2_r});
  assign c_neg = xprod[2*C+1];
  assign c_pos = !c_neg && (xprod != '0);

  always_comb begin
    left    = 1'b0;
    contrib = 3'sd0;
    if ((a_pos_r && b_neg_r) || (a_neg_r && b_pos_r)) begin
      // strict crossing: side from the cross-product sign against sgn(b)
      left    = b_pos_r ? c_neg : c_pos;
      contrib = (left == b_pos_r) ? -3'sd2 : 3'sd2;
    end else if (!a_pos_r && !a_neg_r) begin
      // edge starts on the line
      left = ax_neg_r;
      if (b_pos_r) begin
        contrib = left ? -3'sd1 : 3'sd1;
      end else if (b_neg_r) begin
        contrib = left ? 3'sd1 : -3'sd1;
      end
    end else if (!b_pos_r && !b_neg_r) begin
      // edge ends on the line
      left = axv_neg_r;
      if (a_pos_r) begin
        contrib = left ? 3'sd1 : -3'sd1;
      end else begin
        contrib = left ? -3'sd1 : 3'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_clr) begin
      w_r <= '0;
    end else if (v2_r) begin
      w_r <= w_r + WW'(contrib);
    end
  end

  // ---------------- result register ----------------
  logic out_valid_r, out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load | (out_valid_r & !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= sts.bound_ok && (w_r != '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

  // ---------------- status ----------------
  always_comb begin
    sts.bound_ok   = dist_sq <= CMPW'(radius_r);
    sts.n_zero     = (n_lim == '0);
    sts.last_issue = ((cnt_r + NW'(1)) == n_lim);
    sts.pipe_busy  = v_rd_r | v1_r | v2_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

// ===== rtl/point_in_polygon_winding.sv =====
// Top level of the point-in-polygon block: controller plus datapath.
// Depends on pip_pkg, pip_in_if, pip_out_if, pip_cfg_if, pip_ctrl and pip_dp.
//
// Usage:
//   in_req  carries requests. req_type 0 loads one edge (start x/y, vector dx/dy)
//           into slot edge_index; a slot at or beyond MAX_EDGES is dropped.
//           req_type 1 queries the point (x, y). A load leaves the block idle.
//   out_res returns one inside_res per query, none per load.
//   cfg_wr  writes edge_count, center_x, center_y, radius_sq (index 0..3); it is
//           always ready and must be used only while the block is idle.
// Timing: a query outside the bounding circle, or with no edges in use, goes from
//   the square and compare states straight to its result; otherwise the edges are
//   read one per cycle and drained from the crossing pipeline before the result. The
//   single table read port sets this one-edge-per-cycle pace. Requests are taken one at a
//   time; the next is accepted as soon as the result is in the output register.
// Reset: rst_n (synchronous, active low) clears control state, edge_count and the center
//   and sets radius_sq to all ones; the edge table is undefined until loaded.
// Stalls: a result is held in the output register until out_res.ready; a following
//   query is still walked but holds its result until the register frees.
module point_in_polygon_winding #(
  parameter int MAX_EDGES  = pip_pkg::MAX_EDGES_DEF,
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pip_in_if.sink   in_req,
  pip_out_if.source out_res,
  pip_cfg_if.sink  cfg_wr
);

  pip_pkg::pip_cmd_t cmd;
  pip_pkg::pip_sts_t sts;

  assign cfg_wr.ready = 1'b1;

  pip_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .in_ready    (in_req.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  pip_dp #(
    .MAX_EDGES  (MAX_EDGES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_edge_index  (in_req.edge_index),
    .in_x           (in_req.x),
    .in_y           (in_req.y),
    .in_dx          (in_req.dx),
    .in_dy          (in_req.dy),
    .cfg_we         (cfg_wr.valid & cfg_wr.ready),
    .cfg_index      (cfg_wr.index),
    .cfg_data       (cfg_wr.data),
    .out_ready      (out_res.ready),
    .out_valid      (out_res.valid),
    .out_inside_res (out_res.inside_res)
  );

endmodule
